// ===== rtl/hs_pkg.sv =====
// Shared constants and the signed compare used by the heap sorter.
`timescale 1ns / 1ps
package hs_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_ITEMS_DEF = 64;

    function automatic logic greater(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b);
        greater = (a > b);
    endfunction

endpackage

// ===== rtl/heap_sorter.sv =====
// Top level of the heap sorter: sequencer plus element store.
`timescale 1ns / 1ps
// Words are loaded one per cycle while busy is low (start high); a word beyond
// MAX_ITEMS is dropped and every result of that batch carries overflow. The word
// with is_last set closes the batch: busy rises and the block heap-sorts the
// stored words in place through its single-read-port store, reading the left
// and right child and writing the hole at each heap level visited, after a
// setup per sift that reads its root word or swaps root and end word. The
// results then leave in ascending order, one per cycle, each shown for a single
// cycle with strobe high; the receiver cannot stall them. last_out marks the
// final word of the batch, and busy falls in the cycle that word is shown.
module heap_sorter #(
    parameter int MAX_ITEMS = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [hs_pkg::DATA_W-1:0]  value,
    input  logic                              is_last,
    output logic                              busy,
    output logic                              strobe,
    output logic signed [hs_pkg::DATA_W-1:0]  sorted_value,
    output logic                              last_out,
    output logic                              overflow
);
    import hs_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;

    hs_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .value        (value),
        .is_last      (is_last),
        .busy         (busy),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflow     (overflow),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    hs_ram #(
        .DEPTH (MAX_ITEMS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== rtl/hs_ram.sv =====
// Element store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module hs_ram #(
    parameter int DEPTH = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(DEPTH)-1:0]          waddr,
    input  logic signed [hs_pkg::DATA_W-1:0]  wdata,
    input  logic                              re,
    input  logic [$clog2(DEPTH)-1:0]          raddr,
    output logic signed [hs_pkg::DATA_W-1:0]  rdata
);
    import hs_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/hs_ctrl.sv =====
// Sequencer: load, heap build, extraction and readout over the element store.
`timescale 1ns / 1ps
module hs_ctrl #(
    parameter int MAX_ITEMS = hs_pkg::MAX_ITEMS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [hs_pkg::DATA_W-1:0]     value,
    input  logic                                 is_last,
    output logic                                 busy,
    output logic                                 strobe,
    output logic signed [hs_pkg::DATA_W-1:0]     sorted_value,
    output logic                                 last_out,
    output logic                                 overflow,
    output logic                                 mem_we,
    output logic [$clog2(MAX_ITEMS)-1:0]         mem_waddr,
    output logic signed [hs_pkg::DATA_W-1:0]     mem_wdata,
    output logic                                 mem_re,
    output logic [$clog2(MAX_ITEMS)-1:0]         mem_raddr,
    input  logic signed [hs_pkg::DATA_W-1:0]     mem_rdata
);
    import hs_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_RD_ROOT, S_LD_ROOT, S_CHILD, S_LC, S_RC, S_DECIDE,
        S_SIFT_END, S_SW_RD0, S_SW_RDE, S_SW_WR, S_O_RD, S_O_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    dropped_reg, dropped_next;
    logic [CW-1:0]           n_reg, n_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [CW-1:0]           size_reg, size_next;
    logic                    build_reg, build_next;
    logic [AW-1:0]           i_reg, i_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] bv_reg, bv_next;
    logic [AW-1:0]           best_reg, best_next;
    logic                    best_ok_reg, best_ok_next;
    logic                    strobe_reg, strobe_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic                    last_reg, last_next;
    logic                    ovf_reg, ovf_next;

    logic [IW-1:0]           lc_idx;
    logic [IW-1:0]           rc_idx;
    logic                    has_room;
    logic                    at_last;

    assign lc_idx   = (IW'(i_reg) << 1) + IW'(1);
    assign rc_idx   = lc_idx + IW'(1);
    assign has_room = (count_reg < CW'(MAX_ITEMS));
    assign at_last  = ((CW'(i_reg) + CW'(1)) == n_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        size_next    = size_reg;
        build_next   = build_reg;
        i_next       = i_reg;
        x_next       = x_reg;
        bv_next      = bv_reg;
        best_next    = best_reg;
        best_ok_next = best_ok_reg;
        strobe_next  = 1'b0;
        val_next     = val_reg;
        last_next    = 1'b0;
        ovf_next     = ovf_reg;
        mem_we       = 1'b0;
        mem_waddr    = i_reg;
        mem_wdata    = x_reg;
        mem_re       = 1'b0;
        mem_raddr    = i_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (has_room)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = value;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (is_last)
                    begin
                        n_next     = has_room ? count_reg + CW'(1) : count_reg;
                        state_next = S_SETUP;
                    end
                end
            end
            S_SETUP:
            begin
                if (n_reg < CW'(2))
                begin
                    i_next = '0;
                    if (n_reg == '0)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_O_RD;
                    end
                end
                else
                begin
                    k_next     = n_reg >> 1;
                    size_next  = n_reg;
                    build_next = 1'b1;
                    i_next     = AW'((n_reg >> 1) - CW'(1));
                    state_next = S_RD_ROOT;
                end
            end
            S_RD_ROOT:
            begin
                mem_re     = 1'b1;
                mem_raddr  = i_reg;
                state_next = S_LD_ROOT;
            end
            S_LD_ROOT:
            begin
                x_next     = mem_rdata;
                state_next = S_CHILD;
            end
            S_CHILD:
            begin
                best_ok_next = 1'b0;
                if (lc_idx < IW'(size_reg))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = lc_idx[AW-1:0];
                    state_next = S_LC;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_LC:
            begin
                if (greater(mem_rdata, x_reg))
                begin
                    best_ok_next = 1'b1;
                    bv_next      = mem_rdata;
                    best_next    = lc_idx[AW-1:0];
                end
                if (rc_idx < IW'(size_reg))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = rc_idx[AW-1:0];
                    state_next = S_RC;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_RC:
            begin
                if (greater(mem_rdata, best_ok_reg ? bv_reg : x_reg))
                begin
                    best_ok_next = 1'b1;
                    bv_next      = mem_rdata;
                    best_next    = rc_idx[AW-1:0];
                end
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                // move the larger child up into the hole, or drop the sinking word in
                mem_we    = 1'b1;
                mem_waddr = i_reg;
                if (best_ok_reg)
                begin
                    mem_wdata  = bv_reg;
                    i_next     = best_reg;
                    state_next = S_CHILD;
                end
                else
                begin
                    mem_wdata  = x_reg;
                    state_next = S_SIFT_END;
                end
            end
            S_SIFT_END:
            begin
                if (build_reg)
                begin
                    if (k_reg > CW'(1))
                    begin
                        k_next     = k_reg - CW'(1);
                        i_next     = AW'(k_reg - CW'(2));
                        state_next = S_RD_ROOT;
                    end
                    else
                    begin
                        build_next = 1'b0;
                        k_next     = n_reg - CW'(1);
                        state_next = S_SW_RD0;
                    end
                end
                else if (k_reg == CW'(1))
                begin
                    i_next     = '0;
                    state_next = S_O_RD;
                end
                else
                begin
                    k_next     = k_reg - CW'(1);
                    state_next = S_SW_RD0;
                end
            end
            S_SW_RD0:
            begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_SW_RDE;
            end
            S_SW_RDE:
            begin
                bv_next    = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = k_reg[AW-1:0];
                state_next = S_SW_WR;
            end
            S_SW_WR:
            begin
                // root goes to the end; the end word sinks from the root
                x_next     = mem_rdata;
                mem_we     = 1'b1;
                mem_waddr  = k_reg[AW-1:0];
                mem_wdata  = bv_reg;
                size_next  = k_reg;
                i_next     = '0;
                state_next = S_CHILD;
            end
            S_O_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = i_reg;
                state_next = S_O_EMIT;
            end
            S_O_EMIT:
            begin
                strobe_next = 1'b1;
                val_next    = mem_rdata;
                ovf_next    = dropped_reg;
                last_next   = at_last;
                if (at_last)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    i_next    = i_reg + AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = i_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            build_reg   <= 1'b0;
            best_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            strobe_reg  <= strobe_next;
            last_reg    <= last_next;
            ovf_reg     <= ovf_next;
            build_reg   <= build_next;
            best_ok_reg <= best_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        k_reg    <= k_next;
        size_reg <= size_next;
        i_reg    <= i_next;
        x_reg    <= x_next;
        bv_reg   <= bv_next;
        best_reg <= best_next;
        val_reg  <= val_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = strobe_reg;
    assign sorted_value = val_reg;
    assign last_out     = last_reg;
    assign overflow     = ovf_reg;

endmodule
